>>> design/csvfs_pkg.sv
// shared types and constants of the csv field splitter
package csvfs_pkg;

	localparam int unsigned MAX_FIELDS = 16;
	localparam int unsigned CNT_W      = 5;
	localparam logic [CNT_W-1:0] FIELD_CAP =
		CNT_W'((MAX_FIELDS > 16) ? 16 : MAX_FIELDS);
	localparam logic [CNT_W-1:0] MAX_FIELDS_RST = CNT_W'(3);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		PH_START,
		PH_UNQUOTED,
		PH_QUOTED,
		PH_AFTER
	} phase_t;

	typedef struct packed {
		logic [3:0] field_no;
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       field_end;
		logic       line_done;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		result_t    r0;
		logic [1:0] n;
		result_t    r1;
	} step_res_t;

endpackage

>>> design/csvfs_char_if.sv
// byte channel: one line byte per beat
interface csvfs_char_if;
	import csvfs_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       line_last;

	modport source (output valid, output char_in, output line_last, input ready);
	modport sink   (input valid, input char_in, input line_last, output ready);
endinterface

>>> design/csvfs_field_if.sv
// field channel: one field result per beat
interface csvfs_field_if;
	import csvfs_pkg::*;
	logic       valid;
	logic       ready;
	logic [3:0] field_no;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       field_end;
	logic       line_done;
	logic       last_of_run;

	modport source (output valid, output field_no, output data_byte,
		output byte_valid, output field_end, output line_done,
		output last_of_run, input ready);
	modport sink   (input valid, input field_no, input data_byte,
		input byte_valid, input field_end, input line_done,
		input last_of_run, output ready);
endinterface

>>> design/csvfs_cfg_if.sv
// configuration write channel for the field limit
interface csvfs_cfg_if;
	import csvfs_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] max_fields;

	modport source (output valid, output max_fields, input ready);
	modport sink   (input valid, input max_fields, output ready);
endinterface

>>> design/csvfs_step.sv
// tokeniser state and per-byte step logic
module csvfs_step import csvfs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       c,
	input  logic             last,
	input  logic [CNT_W-1:0] limit,
	output step_res_t        res
);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [7:0]       held_q, held_d;
	logic             held_v_q, held_v_d;

	function automatic result_t close_res(logic [3:0] idx, logic [7:0] hb, logic hv);
		result_t r;
		r = '0;
		r.field_no  = idx;
		r.field_end = 1'b1;
		if (hv && hb != CH_LF && hb != CH_CR) begin
			r.data_byte  = hb;
			r.byte_valid = 1'b1;
		end
		return r;
	endfunction

	logic             open_f;
	logic             do_close;
	logic             do_push;
	logic             first_v;
	logic             second_v;
	phase_t           ph1;
	logic [CNT_W-1:0] count1;
	logic [7:0]       held1;
	logic             held_v1;
	result_t          first_r;
	result_t          second_r;
	result_t          bare_r;

	always_comb begin
		open_f   = count_q < limit;
		do_close = 1'b0;
		do_push  = 1'b0;
		ph1      = phase_q;
		if (open_f) begin
			case (phase_q)
				PH_START, PH_AFTER: begin
					if (phase_q == PH_AFTER && c == CH_COMMA) begin
						ph1 = PH_START;
					end else if (c == CH_QUOTE) begin
						ph1 = PH_QUOTED;
					end else if (c == CH_COMMA) begin
						do_close = 1'b1;
						ph1      = PH_START;
					end else begin
						do_push = 1'b1;
						ph1     = PH_UNQUOTED;
					end
				end
				PH_UNQUOTED: begin
					if (c == CH_COMMA) begin
						do_close = 1'b1;
						ph1      = PH_START;
					end else begin
						do_push = 1'b1;
					end
				end
				default: begin
					if (c == CH_QUOTE) begin
						do_close = 1'b1;
						ph1      = PH_AFTER;
					end else begin
						do_push = 1'b1;
					end
				end
			endcase
		end

		// push emits the previously held byte
		first_r = '0;
		if (do_close) begin
			first_r = close_res(count_q[3:0], held_q, held_v_q);
		end else begin
			first_r.field_no   = count_q[3:0];
			first_r.data_byte  = held_q;
			first_r.byte_valid = 1'b1;
		end
		first_v = do_close || (do_push && held_v_q);

		count1  = do_close ? count_q + CNT_W'(1) : count_q;
		held1   = do_push ? c : (do_close ? 8'h00 : held_q);
		held_v1 = do_push ? 1'b1 : (do_close ? 1'b0 : held_v_q);

		// open field closes at the line end
		second_v = open_f && last && (ph1 == PH_UNQUOTED || ph1 == PH_QUOTED);
		second_r = close_res(count1[3:0], held1, held_v1);

		bare_r = '0;

		res = '0;
		if (first_v) begin
			res.r0 = first_r;
			if (second_v) begin
				res.r1 = second_r;
				res.n  = 2'd2;
			end else begin
				res.n = 2'd1;
			end
		end else if (second_v) begin
			res.r0 = second_r;
			res.n  = 2'd1;
		end else if (last) begin
			res.r0 = bare_r;
			res.n  = 2'd1;
		end
		if (res.n == 2'd2) begin
			res.r1.last_of_run = 1'b1;
			res.r1.line_done   = last;
		end else if (res.n == 2'd1) begin
			res.r0.last_of_run = 1'b1;
			res.r0.line_done   = last;
		end

		if (last) begin
			phase_d  = PH_START;
			count_d  = '0;
			held_d   = 8'h00;
			held_v_d = 1'b0;
		end else begin
			phase_d  = ph1;
			count_d  = count1;
			held_d   = held1;
			held_v_d = held_v1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			count_q  <= '0;
			held_q   <= 8'h00;
			held_v_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			held_q   <= held_d;
			held_v_q <= held_v_d;
		end
	end

endmodule

>>> design/csv_field_splitter.sv
// csv_field_splitter: a line enters one byte per beat on chars and is split
// at commas into fields, quoted fields running to their closing quote; each
// byte yields zero, one or two beats on fields, and a bare result marks a
// line end that closed nothing. A byte is taken every cycle as long as the
// results drain; a byte with two results holds back the next byte, as the
// two-entry result register hands out one beat a cycle while fields is
// ready. The field limit is written on cfg (reset value 3, capped at 16);
// the user must write it only while idle; the block does not enforce it.
module csv_field_splitter import csvfs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	csvfs_char_if.sink          chars,
	csvfs_field_if.source       fields,
	csvfs_cfg_if.sink           cfg
);

	logic [CNT_W-1:0] max_fields_q;
	logic [CNT_W-1:0] limit;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;

	result_t          slot0_q;
	result_t          slot1_q;
	logic [1:0]       cnt_q;

	step_res_t        res;
	logic             pop;
	logic             space;
	logic             fire;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= MAX_FIELDS_RST;
		end else if (cfg.valid) begin
			max_fields_q <= cfg.max_fields;
		end
	end
	assign limit = (max_fields_q > FIELD_CAP) ? FIELD_CAP : max_fields_q;

	// input register
	assign chars.ready = !valid_s1 || fire;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
			last_s1 <= chars.line_last;
		end
	end

	csvfs_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (fire),
		.c       (char_s1),
		.last    (last_s1),
		.limit   (limit),
		.res     (res)
	);

	// result pair register, head beat in slot0
	assign pop   = fields.valid && fields.ready;
	assign space = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign fire  = valid_s1 && (res.n == 2'd0 || space);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (fire && res.n != 2'd0) begin
			cnt_q <= res.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (fire && res.n != 2'd0) begin
			slot0_q <= res.r0;
			slot1_q <= res.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign fields.valid       = cnt_q != 2'd0;
	assign fields.field_no    = slot0_q.field_no;
	assign fields.data_byte   = slot0_q.data_byte;
	assign fields.byte_valid  = slot0_q.byte_valid;
	assign fields.field_end   = slot0_q.field_end;
	assign fields.line_done   = slot0_q.line_done;
	assign fields.last_of_run = slot0_q.last_of_run;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result pair count out of range");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		fields.valid && fields.line_done |-> fields.last_of_run)
		else $error("line_done without last_of_run");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.n == 2'd2 |=> fields.valid && !fields.last_of_run)
		else $error("first of two results marked last");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.n != 2'd0 |-> cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))
		else $error("result register overwritten");

endmodule
